FILE: hdl/assert_macros.svh
// Assertion macros used by the queue of the penalty contact core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/pcf_pkg.sv
// Types, constants and fixed-point helpers for the penalty contact core.
package pcf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int CBRT_BITS  = 21;
  localparam int SQRT_BITS  = 32;
  localparam int DIV_BITS   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STIFFNESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TANGENTIAL_STIFFNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFFICIENT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP            = 2'd3;

  localparam logic [31:0] KN_RESET = 32'd65536;
  localparam logic [31:0] KT_RESET = 32'd65536;
  localparam logic [31:0] MU_RESET = 32'd19661;
  localparam logic [31:0] DT_RESET = 32'd66;

  typedef logic signed [65:0] w_t;
  typedef logic [2:0][31:0]   vec_t;
  typedef logic [2:0][65:0]   wvec_t;

  localparam w_t QMAX = 66'sd2147483647;
  localparam w_t QMIN = -66'sd2147483648;

  typedef struct packed {
    logic              query_valid;
    logic signed [31:0] signed_distance;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] body_vel_x;
    logic signed [31:0] body_vel_y;
    logic signed [31:0] body_vel_z;
    logic [30:0]        particle_volume;
    logic signed [31:0] prev_tang_x;
    logic signed [31:0] prev_tang_y;
    logic signed [31:0] prev_tang_z;
  } in_word_t;

  typedef struct packed {
    logic              in_contact;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] new_tang_x;
    logic signed [31:0] new_tang_y;
    logic signed [31:0] new_tang_z;
  } out_word_t;

  typedef struct packed {
    logic [31:0] kn;
    logic [31:0] kt;
    logic [31:0] mu;
    logic [31:0] dt;
  } cfg_t;

  // classified particle, front to back
  typedef struct packed {
    logic        contact;
    logic [31:0] pen;
    vec_t        n;
    vec_t        v;
    vec_t        prev;
  } fq_t;

  function automatic logic signed [32:0] sext33(logic [31:0] a);
    return {a[31], a};
  endfunction

  function automatic logic signed [32:0] zext33(logic [31:0] a);
    return {1'b0, a};
  endfunction

  function automatic w_t mulw(logic signed [32:0] a, logic signed [32:0] b);
    return w_t'(a) * w_t'(b);
  endfunction

  // floor of x / 2^16
  function automatic w_t fl16(w_t x);
    return x >>> 16;
  endfunction

  function automatic logic [31:0] sat32(w_t x);
    logic [31:0] r;
    if (x > QMAX) begin
      r = 32'h7FFF_FFFF;
    end else if (x < QMIN) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/pcf_front.sv
// Front end: cube root of the volume, penetration and contact classification.
module pcf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pcf_pkg::in_word_t word_i,
  output logic             push_o,
  output pcf_pkg::fq_t     qword_o
);

  localparam int N = pcf_pkg::CBRT_BITS;

  typedef struct packed {
    pcf_pkg::in_word_t w;
    logic [63:0]       x;
    logic [N-1:0]      r;
    logic [63:0]       r2;
    logic [63:0]       r3;
  } cr_t;

  cr_t        cr_q [0:N];
  logic [N:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q[0].w  <= word_i;
    cr_q[0].x  <= 64'({word_i.particle_volume, 32'd0});
    cr_q[0].r  <= '0;
    cr_q[0].r2 <= '0;
    cr_q[0].r3 <= '0;
  end

  // one result bit per stage, squares and cubes kept incrementally
  for (genvar k = 0; k < N; k++) begin : g_cbrt
    localparam int B = N - 1 - k;
    cr_t         nxt;
    logic [63:0] c2;
    logic [63:0] c3;
    always_comb begin
      nxt = cr_q[k];
      c2  = cr_q[k].r2 + (64'(cr_q[k].r) << (B + 1)) + (64'd1 << (2 * B));
      c3  = cr_q[k].r3 + (cr_q[k].r2 << B) + (cr_q[k].r2 << (B + 1))
          + (64'(cr_q[k].r) << (2 * B)) + (64'(cr_q[k].r) << (2 * B + 1))
          + (64'd1 << (3 * B));
      if (c3 <= cr_q[k].x) begin
        nxt.r  = cr_q[k].r | (N'(1) << B);
        nxt.r2 = c2;
        nxt.r3 = c3;
      end
    end
    always_ff @(posedge clk_i) begin
      cr_q[k+1] <= nxt;
    end
  end

  logic [31:0]     pen;
  pcf_pkg::w_t     pen_w;
  pcf_pkg::in_word_t w;

  assign w      = cr_q[N].w;
  assign pen_w  = pcf_pkg::w_t'(pcf_pkg::sext33(w.signed_distance))
                + pcf_pkg::w_t'(cr_q[N].r >> 1);
  assign pen    = pcf_pkg::sat32(pen_w);
  assign push_o = vld_q[N];

  always_comb begin
    qword_o.contact = w.query_valid && ($signed(pen) > 0);
    qword_o.pen     = pen;
    qword_o.n       = {w.normal_z, w.normal_y, w.normal_x};
    qword_o.v       = {w.body_vel_z, w.body_vel_y, w.body_vel_x};
    qword_o.prev    = {w.prev_tang_z, w.prev_tang_y, w.prev_tang_x};
  end

endmodule

FILE: hdl/pcf_fifo.sv
// Short queue between the classifying front end and the force back end.
`include "assert_macros.svh"

module pcf_fifo #(
  parameter int DEPTH = pcf_pkg::FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pcf_pkg::fq_t data_i,
  input  logic         pop_i,
  output pcf_pkg::fq_t data_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcf_pkg::fq_t  mem_q [0:DEPTH-1];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && (!full_o || pop_i);
  assign data_o  = mem_q[rd_q];

  function automatic logic [PW-1:0] nxt_ptr(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt_ptr(rd_q);
      end
      if (do_push && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full_o || pop_i)
  `ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push_i, !empty_o)
  `ASSERT_NEXT(a_idle_stays_empty, clk_i, rst_ni, empty_o && !push_i, empty_o)

endmodule

FILE: hdl/pcf_back.sv
// Back end: normal and tangential forces, length, Coulomb cap and outputs.
module pcf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcf_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  pcf_pkg::fq_t       qword_i,
  output logic               done_o,
  output pcf_pkg::out_word_t word_o
);

  localparam int NA = 10;
  localparam int NS = pcf_pkg::SQRT_BITS;
  localparam int ND = pcf_pkg::DIV_BITS;

  typedef struct packed {
    logic          contact;
    logic [31:0]   pen;
    logic [31:0]   fn;
    logic [31:0]   sn;
    logic [31:0]   pn;
    logic [47:0]   lim;
    pcf_pkg::vec_t n;
    pcf_pkg::vec_t v;
    pcf_pkg::vec_t prev;
    pcf_pkg::vec_t slip;
    pcf_pkg::vec_t fnv;
    pcf_pkg::vec_t st;
    pcf_pkg::vec_t pt;
    pcf_pkg::vec_t ft;
    pcf_pkg::wvec_t pa;
    pcf_pkg::wvec_t pb;
    pcf_pkg::wvec_t pc;
    pcf_pkg::w_t   pm;
    logic [63:0]   sum;
  } ar_t;

  typedef struct packed {
    logic          contact;
    pcf_pkg::vec_t fnv;
    pcf_pkg::vec_t prev;
    pcf_pkg::vec_t ft;
    logic [47:0]   lim;
    logic [63:0]   x;
    logic [63:0]   r2;
    logic [31:0]   r;
  } sq_t;

  typedef struct packed {
    logic          contact;
    pcf_pkg::vec_t fnv;
    pcf_pkg::vec_t prev;
    pcf_pkg::vec_t ft;
    logic          cap;
    logic [31:0]   mag;
    pcf_pkg::wvec_t prod;
  } pp_t;

  typedef struct packed {
    logic             contact;
    pcf_pkg::vec_t    fnv;
    pcf_pkg::vec_t    prev;
    pcf_pkg::vec_t    ft;
    logic             cap;
    logic [31:0]      mag;
    logic [2:0]       sgn;
    logic [2:0][63:0] rem;
    pcf_pkg::vec_t    q;
  } dv_t;

  // arithmetic stages
  ar_t         src  [1:NA];
  ar_t         a_d  [1:NA];
  ar_t         a_q  [1:NA];
  logic [NA:1] av_q;

  always_comb begin
    src[1]         = '0;
    src[1].contact = qword_i.contact;
    src[1].pen     = qword_i.pen;
    src[1].n       = qword_i.n;
    src[1].v       = qword_i.v;
    src[1].prev    = qword_i.prev;
    for (int k = 2; k <= NA; k++) begin
      src[k] = a_q[k-1];
    end
  end

  always_comb begin
    pcf_pkg::w_t lim_w;
    a_d = src;
    a_d[1].pm = pcf_pkg::mulw(pcf_pkg::zext33(cfg_i.kn), pcf_pkg::sext33(src[1].pen));
    for (int i = 0; i < 3; i++) begin
      a_d[1].pa[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[1].v[i]),
                                   pcf_pkg::zext33(cfg_i.dt));
    end
    a_d[2].fn = pcf_pkg::sat32(pcf_pkg::fl16(src[2].pm));
    for (int i = 0; i < 3; i++) begin
      a_d[2].slip[i] = pcf_pkg::sat32(pcf_pkg::fl16(src[2].pa[i]));
    end
    a_d[3].pm = pcf_pkg::mulw(pcf_pkg::zext33(cfg_i.mu), pcf_pkg::sext33(src[3].fn));
    for (int i = 0; i < 3; i++) begin
      a_d[3].pa[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[3].n[i]),
                                   pcf_pkg::sext33(src[3].fn));
      a_d[3].pb[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[3].slip[i]),
                                   pcf_pkg::sext33(src[3].n[i]));
      a_d[3].pc[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[3].prev[i]),
                                   pcf_pkg::sext33(src[3].n[i]));
    end
    for (int i = 0; i < 3; i++) begin
      a_d[4].fnv[i] = pcf_pkg::sat32(pcf_pkg::fl16(src[4].pa[i]));
    end
    a_d[4].sn = pcf_pkg::sat32(pcf_pkg::fl16(src[4].pb[0]) + pcf_pkg::fl16(src[4].pb[1])
                             + pcf_pkg::fl16(src[4].pb[2]));
    a_d[4].pn = pcf_pkg::sat32(pcf_pkg::fl16(src[4].pc[0]) + pcf_pkg::fl16(src[4].pc[1])
                             + pcf_pkg::fl16(src[4].pc[2]));
    lim_w = pcf_pkg::fl16(src[4].pm);
    a_d[4].lim = lim_w[47:0];
    for (int i = 0; i < 3; i++) begin
      a_d[5].pb[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[5].sn),
                                   pcf_pkg::sext33(src[5].n[i]));
      a_d[5].pc[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[5].pn),
                                   pcf_pkg::sext33(src[5].n[i]));
      a_d[6].st[i] = pcf_pkg::sat32(pcf_pkg::w_t'(pcf_pkg::sext33(src[6].slip[i]))
                                  - pcf_pkg::fl16(src[6].pb[i]));
      a_d[6].pt[i] = pcf_pkg::sat32(pcf_pkg::w_t'(pcf_pkg::sext33(src[6].prev[i]))
                                  - pcf_pkg::fl16(src[6].pc[i]));
      a_d[7].pa[i] = pcf_pkg::mulw(pcf_pkg::zext33(cfg_i.kt),
                                   pcf_pkg::sext33(src[7].st[i]));
      a_d[8].ft[i] = pcf_pkg::sat32(pcf_pkg::w_t'(pcf_pkg::sext33(src[8].pt[i]))
          + pcf_pkg::w_t'(pcf_pkg::sext33(pcf_pkg::sat32(pcf_pkg::fl16(src[8].pa[i])))));
      a_d[9].pa[i] = pcf_pkg::mulw(pcf_pkg::sext33(src[9].ft[i]),
                                   pcf_pkg::sext33(src[9].ft[i]));
    end
    a_d[10].sum = src[10].pa[0][63:0] + src[10].pa[1][63:0] + src[10].pa[2][63:0];
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  // square root, one bit per stage
  sq_t         sq_s [0:NS-1];
  sq_t         sq_q [1:NS];
  logic [NS:1] sv_q;

  always_comb begin
    sq_s[0].contact = a_q[NA].contact;
    sq_s[0].fnv     = a_q[NA].fnv;
    sq_s[0].prev    = a_q[NA].prev;
    sq_s[0].ft      = a_q[NA].ft;
    sq_s[0].lim     = a_q[NA].lim;
    sq_s[0].x       = a_q[NA].sum;
    sq_s[0].r2      = '0;
    sq_s[0].r       = '0;
    for (int j = 1; j < NS; j++) begin
      sq_s[j] = sq_q[j];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam int B = NS - 1 - j;
    sq_t         nxt;
    logic [63:0] c2;
    always_comb begin
      nxt = sq_s[j];
      c2  = sq_s[j].r2 + (64'(sq_s[j].r) << (B + 1)) + (64'd1 << (2 * B));
      if (c2 <= sq_s[j].x) begin
        nxt.r  = sq_s[j].r | (32'd1 << B);
        nxt.r2 = c2;
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[j+1] <= nxt;
    end
  end

  // cap decision and numerators
  pp_t  pp_q;
  logic pv_q;

  always_ff @(posedge clk_i) begin
    pp_q.contact <= sq_q[NS].contact;
    pp_q.fnv     <= sq_q[NS].fnv;
    pp_q.prev    <= sq_q[NS].prev;
    pp_q.ft      <= sq_q[NS].ft;
    pp_q.mag     <= sq_q[NS].r;
    pp_q.cap     <= sq_q[NS].lim < 48'(sq_q[NS].r);
    for (int i = 0; i < 3; i++) begin
      pp_q.prod[i] <= pcf_pkg::mulw(pcf_pkg::sext33(sq_q[NS].ft[i]),
                                    pcf_pkg::zext33(sq_q[NS].lim[31:0]));
    end
  end

  // restoring divider, one quotient bit per stage
  dv_t         dv_q [0:ND];
  logic [ND:0] dvv_q;

  always_ff @(posedge clk_i) begin
    pcf_pkg::w_t neg;
    dv_q[0].contact <= pp_q.contact;
    dv_q[0].fnv     <= pp_q.fnv;
    dv_q[0].prev    <= pp_q.prev;
    dv_q[0].ft      <= pp_q.ft;
    dv_q[0].cap     <= pp_q.cap;
    dv_q[0].mag     <= pp_q.mag;
    dv_q[0].q       <= '0;
    for (int i = 0; i < 3; i++) begin
      neg = -$signed(pp_q.prod[i]);
      dv_q[0].sgn[i] <= pp_q.prod[i][65];
      dv_q[0].rem[i] <= pp_q.prod[i][65] ? neg[63:0] : pp_q.prod[i][63:0];
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int B = ND - 1 - j;
    dv_t         nxt;
    logic [63:0] m;
    always_comb begin
      nxt = dv_q[j];
      m   = 64'(dv_q[j].mag) << B;
      for (int i = 0; i < 3; i++) begin
        if (dv_q[j].rem[i] >= m) begin
          nxt.rem[i]  = dv_q[j].rem[i] - m;
          nxt.q[i][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      dv_q[j+1] <= nxt;
    end
  end

  // result assembly
  pcf_pkg::out_word_t word_d;
  pcf_pkg::vec_t      f, t;
  logic               done_q;

  always_comb begin
    logic [31:0] qs, ftc;
    f = '0;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      qs  = dv_q[ND].sgn[i] ? (32'd0 - dv_q[ND].q[i]) : dv_q[ND].q[i];
      ftc = (dv_q[ND].mag == '0) ? 32'd0 : (dv_q[ND].cap ? qs : dv_q[ND].ft[i]);
      f[i] = dv_q[ND].contact ?
             pcf_pkg::sat32(pcf_pkg::w_t'(pcf_pkg::sext33(dv_q[ND].fnv[i]))
                          + pcf_pkg::w_t'(pcf_pkg::sext33(ftc))) : 32'd0;
      t[i] = (dv_q[ND].contact && (dv_q[ND].mag != '0)) ? ftc : dv_q[ND].prev[i];
    end
    word_d.in_contact = dv_q[ND].contact;
    word_d.force_x    = f[0];
    word_d.force_y    = f[1];
    word_d.force_z    = f[2];
    word_d.new_tang_x = t[0];
    word_d.new_tang_y = t[1];
    word_d.new_tang_z = t[2];
  end

  always_ff @(posedge clk_i) begin
    word_o <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q   <= '0;
      sv_q   <= '0;
      pv_q   <= 1'b0;
      dvv_q  <= '0;
      done_q <= 1'b0;
    end else begin
      av_q   <= {av_q[NA-1:1], valid_i};
      sv_q   <= {sv_q[NS-1:1], av_q[NA]};
      pv_q   <= sv_q[NS];
      dvv_q  <= {dvv_q[ND-1:0], pv_q};
      done_q <= dvv_q[ND];
    end
  end

  assign done_o = done_q;

endmodule

FILE: hdl/penalty_contact_friction_force_core.sv
// Top level of the penalty contact force core with Coulomb friction.
//
//   channel  | handshake         | word
//   ---------+-------------------+-------------
//   input    | start / busy      | in_word_i
//   result   | done_o strobe     | out_word_o
//   config   | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// One particle per cycle while busy is low, fully pipelined; the pipeline
// runs through the 21-stage cube root, the queue, 10 arithmetic stages,
// the 32-stage square root, the cap stage and the 32-stage divider of the
// Coulomb cap.
// Reset clears pipeline valids, queue and config to defaults.
// The result side cannot stall; the back end pops whenever the queue is not
// empty, so the queue holds at most one word and busy stays low.
module penalty_contact_friction_force_core #(
  parameter int FIFO_DEPTH = pcf_pkg::FIFO_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  pcf_pkg::in_word_t                 in_word_i,
  output logic                              done_o,
  output pcf_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  pcf_pkg::cfg_t cfg_q;
  pcf_pkg::fq_t  fr_word, bk_word;
  logic          fr_push, q_empty, q_full, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kn <= pcf_pkg::KN_RESET;
      cfg_q.kt <= pcf_pkg::KT_RESET;
      cfg_q.mu <= pcf_pkg::MU_RESET;
      cfg_q.dt <= pcf_pkg::DT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcf_pkg::CFG_NORMAL_STIFFNESS:     cfg_q.kn <= cfg_wdata_i;
        pcf_pkg::CFG_TANGENTIAL_STIFFNESS: cfg_q.kt <= cfg_wdata_i;
        pcf_pkg::CFG_FRICTION_COEFFICIENT: cfg_q.mu <= cfg_wdata_i;
        pcf_pkg::CFG_TIME_STEP:            cfg_q.dt <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy  = q_full;
  assign q_pop = !q_empty;

  pcf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .word_i  (in_word_i),
    .push_o  (fr_push),
    .qword_o (fr_word)
  );

  pcf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_word),
    .pop_i   (q_pop),
    .data_o  (bk_word),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  pcf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_pop),
    .qword_i (bk_word),
    .done_o  (done_o),
    .word_o  (out_word_o)
  );

endmodule
